### sv/evma_pkg.sv
// Shared constants, command and status types for the encoder velocity averager.
package evma_pkg;

  localparam int AVG_DEPTH  = 8;
  localparam int RING_AW    = $clog2(AVG_DEPTH);
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = SAMPLE_W + RING_AW;
  localparam int DIST_W     = 24;
  localparam int QUO_W      = 42;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int SCALED_W   = 51;

  localparam logic [DIST_W-1:0]   DIST_RESET = DIST_W'(65536);
  localparam logic [QUO_W-1:0]    RATE_SCALE = QUO_W'(1000);
  localparam logic [STEP_W-1:0]   LAST_STEP  = STEP_W'(QUO_W - 1);
  localparam logic [SCALED_W-1:0] POS_LIMIT  = SCALED_W'(64'h7FFF_FFFF);
  localparam logic [SCALED_W-1:0] NEG_LIMIT  = SCALED_W'(64'h8000_0000);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SETUP  = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_MUL_LO = 8'b0000_1000,
    ST_MUL_HI = 8'b0001_0000,
    ST_SAT    = 8'b0010_0000,
    ST_UPD    = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic setup;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic sat;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### sv/evma_ctrl.sv
// Controller state machine sequencing one beat through the velocity datapath.
module evma_ctrl import evma_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t stat_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = stat_i.dt_zero ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/evma_dp.sv
// Datapath: deltas, bit-serial divider, Q8.16 scaling, sample ring and output register.
module evma_dp import evma_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             stat_o,
  input  logic [31:0]         in_count_i,
  input  logic [31:0]         in_time_i,
  input  logic                cfg_valid_i,
  input  logic [DIST_W-1:0]   cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_vel_o,
  output logic                out_zero_o
);

  logic [31:0]          cnt_q, tms_q;
  logic [31:0]          prev_cnt_q, prev_tms_q;
  logic [31:0]          dt_q;
  logic                 neg_q, zero_q;
  logic [QUO_W-1:0]     quo_q;
  logic [31:0]          rem_q;
  logic [STEP_W-1:0]    step_q;
  logic [DIST_W-1:0]    dist_q;
  logic [55:0]          plo_q;
  logic [33:0]          phi_q;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [SAMPLE_W-1:0]  ring_q [AVG_DEPTH];
  logic [RING_AW-1:0]   pos_q;
  logic [SUM_W-1:0]     sum_q;
  logic                 out_valid_q, out_zero_q;
  logic [31:0]          out_vel_q;

  logic [31:0]          dt_now, draw, mag;
  logic [QUO_W-1:0]     dividend;
  logic [32:0]          rem_sh, rem_sub;
  logic                 q_bit;
  logic [SCALED_W-1:0]  scaled, limit;
  logic [31:0]          clamped;
  logic [SUM_W-1:0]     sum_d;

  assign dt_now   = tms_q - prev_tms_q;
  assign draw     = cnt_q - prev_cnt_q;
  assign mag      = draw[31] ? (32'd0 - draw) : draw;
  assign dividend = QUO_W'(mag) * RATE_SCALE;

  // restoring division, one quotient bit per step
  assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, dt_q};
  assign q_bit   = !rem_sub[32];

  assign scaled  = {1'b0, phi_q, 16'd0} + SCALED_W'(plo_q[55:16]);
  assign limit   = neg_q ? NEG_LIMIT : POS_LIMIT;
  assign clamped = (scaled > limit) ? limit[31:0] : scaled[31:0];

  assign sum_d = sum_q - {{RING_AW{ring_q[pos_q][SAMPLE_W-1]}}, ring_q[pos_q]}
                       + {{RING_AW{sample_q[SAMPLE_W-1]}}, sample_q};

  assign stat_o.dt_zero  = (dt_now == 32'd0);
  assign stat_o.div_done = (step_q == LAST_STEP);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_vel_o   = out_vel_q;
  assign out_zero_o  = out_zero_q;

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cnt_q <= in_count_i;
      tms_q <= in_time_i;
    end
    if (cmd_i.setup) begin
      dt_q   <= dt_now;
      neg_q  <= draw[31];
      quo_q  <= dividend;
      rem_q  <= '0;
      step_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
      quo_q  <= {quo_q[QUO_W-2:0], q_bit};
      step_q <= step_q + STEP_W'(1);
    end
    if (cmd_i.mul_lo) plo_q <= 56'(quo_q[31:0]) * 56'(dist_q);
    if (cmd_i.mul_hi) phi_q <= 34'(quo_q[QUO_W-1:32]) * 34'(dist_q);
    if (cmd_i.sat) sample_q <= neg_q ? (32'd0 - clamped) : clamped;
    if (cmd_i.emit) begin
      out_vel_q  <= sum_q[SUM_W-1:RING_AW];
      out_zero_q <= zero_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cnt_q  <= '0;
      prev_tms_q  <= '0;
      zero_q      <= 1'b0;
      dist_q      <= DIST_RESET;
      for (int i = 0; i < AVG_DEPTH; i++) ring_q[i] <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) dist_q <= cfg_data_i;
      if (cmd_i.setup) zero_q <= stat_o.dt_zero;
      if (cmd_i.update) begin
        ring_q[pos_q] <= sample_q;
        sum_q         <= sum_d;
        pos_q         <= pos_q + RING_AW'(1);
        prev_cnt_q    <= cnt_q;
        prev_tms_q    <= tms_q;
      end
      // load on emit, drop once the beat is taken
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### sv/encoder_velocity_moving_average_top.sv
// Top level of the encoder velocity moving-average block.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: encoder_count, time_ms
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: avg_velocity; tuser: zero_interval
//  cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i: dist_per_tick_q16
//
// A beat with a nonzero time delta is loaded into the output register after setup, the
// bit-serial division of the 42-bit dividend, two multiplies, saturation and ring update,
// in that order. A zero time delta skips from setup straight to the load.
// The next beat is accepted the cycle after the load; a stalled result holds the
// controller in its final state.
// Reset clears the ring, running sum, previous count/time and sets the scale to 1.0.
module encoder_velocity_moving_average_top import evma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // [31:0] encoder_count, [63:32] time_ms
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [31:0] avg_velocity
  output logic              m_axis_tuser,   // [0] zero_interval
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DIST_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t stat;

  assign cfg_ready_o = 1'b1;

  evma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  evma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_count_i  (s_axis_tdata[31:0]),
    .in_time_i   (s_axis_tdata[63:32]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_vel_o   (m_axis_tdata),
    .out_zero_o  (m_axis_tuser)
  );

endmodule
